### sv/rsc_pkg.sv
package rsc_pkg;

    localparam int WORD_W          = 32;
    localparam int CMD_W           = 3;
    localparam int STATUS_W        = 2;
    localparam int DEPTH_OUT_W     = 7;
    localparam int STACK_DEPTH_DEF = 64;

    typedef logic [CMD_W-1:0]    cmd_t;
    typedef logic [STATUS_W-1:0] status_t;

    localparam cmd_t CMD_PUSH = 3'd0;
    localparam cmd_t CMD_ADD  = 3'd1;
    localparam cmd_t CMD_SUB  = 3'd2;
    localparam cmd_t CMD_MUL  = 3'd3;
    localparam cmd_t CMD_DIV  = 3'd4;
    localparam cmd_t CMD_POW  = 3'd5;
    localparam cmd_t CMD_REM  = 3'd6;
    localparam cmd_t CMD_NOP  = 3'd7;

    localparam status_t ST_OK      = 2'd0;
    localparam status_t ST_UNDER   = 2'd1;
    localparam status_t ST_DIVZERO = 2'd2;
    localparam status_t ST_OVER    = 2'd3;

    typedef struct packed {
        logic              start;
        cmd_t              op;
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
    } alu_req_t;

    typedef struct packed {
        logic              done;
        logic              good;
        logic [WORD_W-1:0] result;
    } alu_rsp_t;

    function automatic logic [WORD_W-1:0] mag(input logic [WORD_W-1:0] v);
        return v[WORD_W-1] ? (~v + 1'b1) : v;
    endfunction

endpackage

### sv/rsc_alu.sv
module rsc_alu
(
    input  logic              clk,
    input  logic              rst_n,
    input  rsc_pkg::alu_req_t req,
    output rsc_pkg::alu_rsp_t rsp
);

    typedef enum logic [5:0] {
        A_IDLE   = 6'b000001,
        A_DIV    = 6'b000010,
        A_DIVFIX = 6'b000100,
        A_PACC   = 6'b001000,
        A_PSQ    = 6'b010000,
        A_DONE   = 6'b100000
    } alu_state_t;

    alu_state_t  state_reg, state_next;
    logic [31:0] acc_reg, acc_next;
    logic [31:0] sq_reg, sq_next;
    logic [30:0] ex_reg, ex_next;
    logic [31:0] quo_reg, quo_next;
    logic [32:0] rem_reg, rem_next;
    logic [31:0] dvs_reg, dvs_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        negq_reg, negq_next;
    logic        negr_reg, negr_next;
    logic        isrem_reg, isrem_next;
    logic        good_reg, good_next;

    logic [31:0] mul_x, mul_y;
    logic [63:0] prod_full;
    logic [31:0] prod;
    logic [32:0] rem_sh, diff;

    always_comb
    begin
        unique case (state_reg)
            A_PACC:
            begin
                mul_x = acc_reg;
                mul_y = sq_reg;
            end
            A_PSQ:
            begin
                mul_x = sq_reg;
                mul_y = sq_reg;
            end
            default:
            begin
                mul_x = req.a;
                mul_y = req.b;
            end
        endcase
    end

    assign prod_full = mul_x * mul_y;
    assign prod      = prod_full[31:0];
    assign rem_sh    = {rem_reg[31:0], quo_reg[31]};
    assign diff      = rem_sh - {1'b0, dvs_reg};

    always_comb
    begin
        state_next = state_reg;
        acc_next   = acc_reg;
        sq_next    = sq_reg;
        ex_next    = ex_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        dvs_next   = dvs_reg;
        cnt_next   = cnt_reg;
        negq_next  = negq_reg;
        negr_next  = negr_reg;
        isrem_next = isrem_reg;
        good_next  = good_reg;
        unique case (state_reg)
            A_IDLE:
            begin
                if (req.start)
                begin
                    good_next  = 1'b1;
                    state_next = A_DONE;
                    unique case (req.op)
                        rsc_pkg::CMD_ADD: acc_next = req.a + req.b;
                        rsc_pkg::CMD_SUB: acc_next = req.a - req.b;
                        rsc_pkg::CMD_MUL: acc_next = prod;
                        rsc_pkg::CMD_DIV, rsc_pkg::CMD_REM:
                        begin
                            if (req.b == 32'd0)
                            begin
                                good_next = 1'b0;
                            end
                            else
                            begin
                                quo_next   = rsc_pkg::mag(req.a);
                                dvs_next   = rsc_pkg::mag(req.b);
                                rem_next   = '0;
                                cnt_next   = '0;
                                negq_next  = req.a[31] ^ req.b[31];
                                negr_next  = req.a[31];
                                isrem_next = (req.op == rsc_pkg::CMD_REM);
                                state_next = A_DIV;
                            end
                        end
                        rsc_pkg::CMD_POW:
                        begin
                            if (req.b[31])
                            begin
                                if (req.a == 32'd0)
                                begin
                                    good_next = 1'b0;
                                end
                                else if (req.a == 32'd1)
                                begin
                                    acc_next = 32'd1;
                                end
                                else if (req.a == 32'hFFFF_FFFF)
                                begin
                                    acc_next = req.b[0] ? 32'hFFFF_FFFF : 32'd1;
                                end
                                else
                                begin
                                    acc_next = 32'd0;
                                end
                            end
                            else
                            begin
                                acc_next   = 32'd1;
                                sq_next    = req.a;
                                ex_next    = req.b[30:0];
                                state_next = A_PACC;
                            end
                        end
                        default: acc_next = 32'd0;
                    endcase
                end
            end
            A_DIV:
            begin
                if (!diff[32])
                begin
                    rem_next = diff;
                    quo_next = {quo_reg[30:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_sh;
                    quo_next = {quo_reg[30:0], 1'b0};
                end
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    state_next = A_DIVFIX;
                end
            end
            A_DIVFIX:
            begin
                if (isrem_reg)
                begin
                    acc_next = negr_reg ? (~rem_reg[31:0] + 32'd1) : rem_reg[31:0];
                end
                else
                begin
                    acc_next = negq_reg ? (~quo_reg + 32'd1) : quo_reg;
                end
                good_next  = 1'b1;
                state_next = A_DONE;
            end
            A_PACC:
            begin
                if (ex_reg == 31'd0)
                begin
                    state_next = A_DONE;
                end
                else
                begin
                    if (ex_reg[0])
                    begin
                        acc_next = prod;
                    end
                    state_next = A_PSQ;
                end
            end
            A_PSQ:
            begin
                sq_next    = prod;
                ex_next    = {1'b0, ex_reg[30:1]};
                state_next = A_PACC;
            end
            A_DONE:
            begin
                state_next = A_IDLE;
            end
            default:
            begin
                state_next = A_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= A_IDLE;
            cnt_reg   <= '0;
            good_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            good_reg  <= good_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg   <= acc_next;
        sq_reg    <= sq_next;
        ex_reg    <= ex_next;
        quo_reg   <= quo_next;
        rem_reg   <= rem_next;
        dvs_reg   <= dvs_next;
        negq_reg  <= negq_next;
        negr_reg  <= negr_next;
        isrem_reg <= isrem_next;
    end

    assign rsp.done   = (state_reg == A_DONE);
    assign rsp.good   = good_reg;
    assign rsp.result = acc_reg;

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.done |=> !rsp.done)
        else $error("alu done held longer than one cycle");

    a_div_entry: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(state_reg == A_DIV) |-> (cnt_reg == 5'd0))
        else $error("divide entered with stale count");

    a_div_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == A_DIV && cnt_reg == 5'd31) |=> (state_reg == A_DIVFIX))
        else $error("divide did not finish after 32 steps");

endmodule

### sv/rpn_stack_calculator_unit.sv
// channel  | direction | handshake             | payload
// ---------+-----------+-----------------------+---------------------------
// command  | in        | cmd_valid / cmd_stall | command, literal
// result   | out       | res_valid / res_stall | status, top_value, depth
//
// Push, unused command, underflow, overflow: go from accept straight to the result state.
// Add, subtract, multiply, zero divisor, negative exponent: stack read, then the ALU with no iteration.
// Divide and remainder: iterate in the one-bit-per-cycle divider, then fix the signs.
// Power: square-and-multiply over the exponent bits on the shared 32x32 multiplier.
// Reset clears depth and handshake state; the stack memory is not cleared.
// A stalled result holds the sequencer in its final state and stalls new words.
module rpn_stack_calculator_unit
#(
    parameter int STACK_DEPTH = rsc_pkg::STACK_DEPTH_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_stall,
    input  logic [2:0]         command,
    input  logic [30:0]        literal,
    output logic               res_valid,
    input  logic               res_stall,
    output logic [1:0]         status,
    output logic signed [31:0] top_value,
    output logic [6:0]         depth
);

    localparam int DW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);

    typedef enum logic [4:0] {
        T_IDLE = 5'b00001,
        T_READ = 5'b00010,
        T_EXEC = 5'b00100,
        T_WAIT = 5'b01000,
        T_DONE = 5'b10000
    } seq_state_t;

    seq_state_t        state_reg, state_next;
    logic [DW-1:0]     depth_reg, depth_next;
    logic [31:0]       top_reg, top_next;
    rsc_pkg::status_t  status_reg, status_next;
    rsc_pkg::cmd_t     cmd_reg, cmd_next;
    logic              res_valid_reg, res_valid_next;
    rsc_pkg::status_t  res_status_reg, res_status_next;
    logic [31:0]       res_top_reg, res_top_next;
    logic [6:0]        res_depth_reg, res_depth_next;

    logic [31:0]       mem [STACK_DEPTH];
    logic [31:0]       rd_reg;
    logic              mem_we, mem_re;
    logic [AW-1:0]     mem_waddr, mem_raddr;
    logic [31:0]       mem_wdata;

    logic [DW-1:0]     depth_m2;
    logic [DW+6:0]     depth_ext;
    logic              accept, res_free;

    rsc_pkg::alu_req_t alu_req;
    rsc_pkg::alu_rsp_t alu_rsp;

    rsc_alu u_alu
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (alu_req),
        .rsp   (alu_rsp)
    );

    assign cmd_stall = (state_reg != T_IDLE);
    assign accept    = cmd_valid && !cmd_stall;
    assign res_free  = !res_valid_reg || !res_stall;
    assign depth_m2  = depth_reg - DW'(2);
    assign depth_ext = {7'd0, depth_reg};

    always_comb
    begin
        state_next      = state_reg;
        depth_next      = depth_reg;
        top_next        = top_reg;
        status_next     = status_reg;
        cmd_next        = cmd_reg;
        mem_we          = 1'b0;
        mem_re          = 1'b0;
        mem_waddr       = depth_reg[AW-1:0];
        mem_wdata       = {1'b0, literal};
        mem_raddr       = depth_m2[AW-1:0];
        alu_req.start   = 1'b0;
        alu_req.op      = cmd_reg;
        alu_req.a       = rd_reg;
        alu_req.b       = top_reg;
        res_valid_next  = res_valid_reg && res_stall;
        res_status_next = res_status_reg;
        res_top_next    = res_top_reg;
        res_depth_next  = res_depth_reg;
        unique case (state_reg)
            T_IDLE:
            begin
                if (accept)
                begin
                    cmd_next    = command;
                    status_next = rsc_pkg::ST_OK;
                    state_next  = T_DONE;
                    if (command == rsc_pkg::CMD_PUSH)
                    begin
                        if (depth_reg == DW'(STACK_DEPTH))
                        begin
                            status_next = rsc_pkg::ST_OVER;
                        end
                        else
                        begin
                            mem_we     = 1'b1;
                            top_next   = {1'b0, literal};
                            depth_next = depth_reg + DW'(1);
                        end
                    end
                    else if (command != rsc_pkg::CMD_NOP)
                    begin
                        if (depth_reg < DW'(2))
                        begin
                            status_next = rsc_pkg::ST_UNDER;
                        end
                        else
                        begin
                            mem_re     = 1'b1;
                            state_next = T_READ;
                        end
                    end
                end
            end
            T_READ:
            begin
                state_next = T_EXEC;
            end
            T_EXEC:
            begin
                alu_req.start = 1'b1;
                state_next    = T_WAIT;
            end
            T_WAIT:
            begin
                if (alu_rsp.done)
                begin
                    if (alu_rsp.good)
                    begin
                        mem_we     = 1'b1;
                        mem_waddr  = depth_m2[AW-1:0];
                        mem_wdata  = alu_rsp.result;
                        top_next   = alu_rsp.result;
                        depth_next = depth_reg - DW'(1);
                    end
                    else
                    begin
                        status_next = rsc_pkg::ST_DIVZERO;
                    end
                    state_next = T_DONE;
                end
            end
            T_DONE:
            begin
                if (res_free)
                begin
                    res_valid_next  = 1'b1;
                    res_status_next = status_reg;
                    res_top_next    = (depth_reg != '0) ? top_reg : 32'd0;
                    res_depth_next  = depth_ext[6:0];
                    state_next      = T_IDLE;
                end
            end
            default:
            begin
                state_next = T_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_reg <= mem[mem_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= T_IDLE;
            depth_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            depth_reg     <= depth_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg        <= top_next;
        status_reg     <= status_next;
        cmd_reg        <= cmd_next;
        res_status_reg <= res_status_next;
        res_top_reg    <= res_top_next;
        res_depth_reg  <= res_depth_next;
    end

    assign res_valid = res_valid_reg;
    assign status    = res_status_reg;
    assign top_value = res_top_reg;
    assign depth     = res_depth_reg;

    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= DW'(STACK_DEPTH))
        else $error("stack depth beyond capacity");

    a_alu_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        alu_rsp.done |-> (state_reg == T_WAIT))
        else $error("alu finished outside wait state");

    a_depth_step: assert property (@(posedge clk) disable iff (!rst_n)
        (depth_reg != $past(depth_reg)) |->
            (depth_reg == $past(depth_reg) + DW'(1) ||
             depth_reg == $past(depth_reg) - DW'(1)))
        else $error("stack depth moved by more than one");

endmodule

### tb/rpn_stack_calculator_unit_tb.sv
`timescale 1ns / 1ps

module rpn_stack_calculator_unit_tb;

    localparam int CALC_DEPTH  = rsc_pkg::STACK_DEPTH_DEF;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int TAIL_CYCLES = 80;

    typedef struct {
        rsc_pkg::status_t st;
        logic [31:0]      top;
        logic [6:0]       dep;
    } calc_result_t;

    logic               clk;
    logic               rst_n;
    logic               cmd_valid;
    logic               cmd_stall;
    logic [2:0]         command;
    logic [30:0]        literal;
    logic               res_valid;
    logic               res_stall;
    logic [1:0]         status;
    logic signed [31:0] top_value;
    logic [6:0]         depth;

    logic [31:0]  stack_mem [CALC_DEPTH];
    int           stack_count;
    calc_result_t due_results [$];

    int send_idle_pct;
    int recv_stall_pct;
    int cycle_count;
    int error_count;
    int words_sent;
    int results_checked;
    int status_seen [4];

    rpn_stack_calculator_unit
    #(
        .STACK_DEPTH (CALC_DEPTH)
    )
    uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .command   (command),
        .literal   (literal),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .status    (status),
        .top_value (top_value),
        .depth     (depth)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    initial
    begin
        while (cycle_count <= CYCLE_LIMIT)
            @(posedge clk);
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycle_count, due_results.size());
        $display("** rpn_stack_calculator_unit: FAILED **");
        $finish;
    end

    initial
    begin
        res_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            res_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    task automatic report_mismatch(input string what);
        error_count++;
        $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    function automatic logic [31:0] int_power(input logic [31:0] base,
                                              input logic [31:0] ex);
        logic [31:0] acc;
        logic [31:0] sq;
        int          i;
        acc = 32'd1;
        sq  = base;
        for (i = 0; i < 32; i++)
        begin
            if (ex[i])
                acc = acc * sq;
            sq = sq * sq;
        end
        return acc;
    endfunction

    function automatic void apply_instruction(input rsc_pkg::cmd_t op,
                                              input logic [30:0] lit);
        logic [31:0]  lhs;
        logic [31:0]  rhs;
        logic [31:0]  lmag;
        logic [31:0]  rmag;
        logic [31:0]  part;
        logic [31:0]  res;
        logic         fault;
        calc_result_t outcome;
        outcome.st = rsc_pkg::ST_OK;
        res        = '0;
        fault      = 1'b0;
        case (op)
            rsc_pkg::CMD_PUSH:
            begin
                if (stack_count >= CALC_DEPTH)
                    outcome.st = rsc_pkg::ST_OVER;
                else
                begin
                    stack_mem[stack_count] = {1'b0, lit};
                    stack_count++;
                end
            end
            rsc_pkg::CMD_NOP:
            begin
            end
            default:
            begin
                if (stack_count < 2)
                    outcome.st = rsc_pkg::ST_UNDER;
                else
                begin
                    lhs  = stack_mem[stack_count-2];
                    rhs  = stack_mem[stack_count-1];
                    lmag = lhs[31] ? -lhs : lhs;
                    rmag = rhs[31] ? -rhs : rhs;
                    case (op)
                        rsc_pkg::CMD_ADD: res = lhs + rhs;
                        rsc_pkg::CMD_SUB: res = lhs - rhs;
                        rsc_pkg::CMD_MUL: res = lhs * rhs;
                        rsc_pkg::CMD_DIV:
                        begin
                            if (rhs == '0)
                                fault = 1'b1;
                            else
                            begin
                                part = lmag / rmag;
                                res  = (lhs[31] ^ rhs[31]) ? -part : part;
                            end
                        end
                        rsc_pkg::CMD_REM:
                        begin
                            if (rhs == '0)
                                fault = 1'b1;
                            else
                            begin
                                part = lmag % rmag;
                                res  = lhs[31] ? -part : part;
                            end
                        end
                        rsc_pkg::CMD_POW:
                        begin
                            if (!rhs[31])
                                res = int_power(lhs, rhs);
                            else if (lhs == '0)
                                fault = 1'b1;
                            else if (lhs == 32'd1)
                                res = 32'd1;
                            else if (lhs == '1)
                                res = rhs[0] ? '1 : 32'd1;
                            else
                                res = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                    if (fault)
                        outcome.st = rsc_pkg::ST_DIVZERO;
                    else
                    begin
                        stack_count--;
                        stack_mem[stack_count-1] = res;
                    end
                end
            end
        endcase
        outcome.top = (stack_count > 0) ? stack_mem[stack_count-1] : '0;
        outcome.dep = stack_count[6:0];
        status_seen[outcome.st]++;
        due_results.push_back(outcome);
    endfunction

    always @(posedge clk)
    begin
        calc_result_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            results_checked++;
            if (due_results.size() == 0)
                report_mismatch($sformatf("unexpected result status=%0d top=%0d depth=%0d",
                                          status, top_value, depth));
            else
            begin
                want = due_results.pop_front();
                if (status !== want.st)
                    report_mismatch($sformatf("result %0d status %0d, expected %0d",
                                              results_checked, status, want.st));
                if (top_value !== want.top)
                    report_mismatch($sformatf("result %0d top %h, expected %h",
                                              results_checked, top_value, want.top));
                if (depth !== want.dep)
                    report_mismatch($sformatf("result %0d depth %0d, expected %0d",
                                              results_checked, depth, want.dep));
            end
        end
    end

    task automatic send_word(input rsc_pkg::cmd_t op, input logic [30:0] lit);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid <= 1'b1;
        command   <= op;
        literal   <= lit;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        apply_instruction(op, lit);
        words_sent++;
    endtask

    task automatic wait_drained();
        cmd_valid <= 1'b0;
        @(posedge clk);
        while (due_results.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [30:0] pick_literal();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 40)
            return 31'($urandom_range(0, 3));
        else if (sel < 60)
            return 31'($urandom_range(0, 255));
        else if (sel < 70)
            return 31'h7FFF_FFFF - 31'($urandom_range(0, 2));
        else
            return 31'($urandom());
    endfunction

    function automatic rsc_pkg::cmd_t pick_operator();
        return rsc_pkg::cmd_t'($urandom_range(rsc_pkg::CMD_ADD, rsc_pkg::CMD_REM));
    endfunction

    task automatic fill_stack();
        while (stack_count < CALC_DEPTH)
            send_word(rsc_pkg::CMD_PUSH, pick_literal());
        send_word(rsc_pkg::CMD_PUSH, pick_literal());
    endtask

    task automatic random_word(output rsc_pkg::cmd_t op);
        int sel;
        sel = $urandom_range(0, 99);
        if (stack_count < 2)
            op = (sel < 80) ? rsc_pkg::CMD_PUSH : pick_operator();
        else if (sel < 42)
            op = rsc_pkg::CMD_PUSH;
        else if (sel < 45)
            op = rsc_pkg::CMD_NOP;
        else
            op = pick_operator();
        send_word(op, (op == rsc_pkg::CMD_PUSH) ? pick_literal() : 31'($urandom()));
    endtask

    task automatic test_directed_corner_cases();
        send_word(rsc_pkg::CMD_ADD, 31'd0);
        send_word(rsc_pkg::CMD_NOP, 31'h7FFF_FFFF);
        send_word(rsc_pkg::CMD_PUSH, 31'd0);
        send_word(rsc_pkg::CMD_MUL, 31'd0);
        send_word(rsc_pkg::CMD_PUSH, 31'h7FFF_FFFF);
        send_word(rsc_pkg::CMD_PUSH, 31'd1);
        send_word(rsc_pkg::CMD_ADD, 31'd0);
        send_word(rsc_pkg::CMD_PUSH, 31'd0);
        send_word(rsc_pkg::CMD_DIV, 31'd0);
        send_word(rsc_pkg::CMD_REM, 31'd0);
        send_word(rsc_pkg::CMD_PUSH, 31'd1);
        send_word(rsc_pkg::CMD_SUB, 31'd0);
        send_word(rsc_pkg::CMD_DIV, 31'd0);
        send_word(rsc_pkg::CMD_PUSH, 31'd0);
        send_word(rsc_pkg::CMD_PUSH, 31'd1);
        send_word(rsc_pkg::CMD_SUB, 31'd0);
        send_word(rsc_pkg::CMD_REM, 31'd0);
        send_word(rsc_pkg::CMD_PUSH, 31'd0);
        send_word(rsc_pkg::CMD_PUSH, 31'd1);
        send_word(rsc_pkg::CMD_SUB, 31'd0);
        send_word(rsc_pkg::CMD_POW, 31'd0);
        send_word(rsc_pkg::CMD_MUL, 31'd0);
        send_word(rsc_pkg::CMD_POW, 31'd0);
        send_word(rsc_pkg::CMD_PUSH, 31'd0);
        send_word(rsc_pkg::CMD_PUSH, 31'd1);
        send_word(rsc_pkg::CMD_SUB, 31'd0);
        send_word(rsc_pkg::CMD_POW, 31'd0);
        wait_drained();
    endtask

    task automatic test_stack_full();
        fill_stack();
        send_word(rsc_pkg::CMD_PUSH, 31'h7FFF_FFFF);
        send_word(rsc_pkg::CMD_NOP, 31'd0);
        send_word(rsc_pkg::CMD_ADD, 31'd0);
        send_word(rsc_pkg::CMD_PUSH, 31'd5);
        while (stack_count >= 2)
            send_word(pick_operator(), 31'($urandom()));
        send_word(rsc_pkg::CMD_MUL, 31'd0);
        wait_drained();
    endtask

    task automatic test_random_program(input int words, input int idle_pct,
                                       input int stall_pct);
        int            done_words;
        rsc_pkg::cmd_t op;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        done_words     = 0;
        while (done_words < words)
        begin
            if ($urandom_range(0, 299) == 0)
                fill_stack();
            else
            begin
                random_word(op);
                if (op != rsc_pkg::CMD_NOP)
                    done_words++;
            end
        end
        wait_drained();
    endtask

    initial
    begin
        rst_n           = 1'b0;
        cmd_valid       = 1'b0;
        command         = rsc_pkg::CMD_NOP;
        literal         = '0;
        cycle_count     = 0;
        error_count     = 0;
        words_sent      = 0;
        results_checked = 0;
        stack_count     = 0;
        send_idle_pct   = 6;
        recv_stall_pct  = 61;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_corner_cases();
        test_stack_full();
        test_random_program(450, 6, 61);
        test_random_program(450, 61, 6);
        test_random_program(450, 0, 0);

        repeat (TAIL_CYCLES) @(posedge clk);
        $display("%0d instruction words sent, %0d results checked, %0d mismatches",
                 words_sent, results_checked, error_count);
        $display("faults covered: %0d underflow, %0d zero divisor, %0d overflow",
                 status_seen[rsc_pkg::ST_UNDER], status_seen[rsc_pkg::ST_DIVZERO],
                 status_seen[rsc_pkg::ST_OVER]);
        if (error_count == 0 && due_results.size() == 0)
            $display("** rpn_stack_calculator_unit: PASSED **");
        else
            $display("** rpn_stack_calculator_unit: FAILED **");
        $finish;
    end

endmodule

### rpn_stack_calculator_unit.f
sv/rsc_pkg.sv
sv/rsc_alu.sv
sv/rpn_stack_calculator_unit.sv
tb/rpn_stack_calculator_unit_tb.sv
